FILE: rtl/sha256bsh_pkg.sv
package sha256bsh_pkg;

    // Field and storage widths
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int EXTRA_W     = 3;
    localparam int IDX_W       = 3;
    localparam int FILL_W      = 7;
    localparam int LEN_W       = 64;
    localparam int ROUND_W     = 6;
    localparam int HASH_WORDS  = 8;
    localparam int BLOCK_BYTES = 64;
    localparam int BLOCK_W     = BLOCK_BYTES * BYTE_W;
    localparam int LEN_START   = 56;
    localparam int ROUNDS      = 64;

    // Number of digest words sent per message (1 to 8)
    localparam int DIGEST_WORDS = 8;

    // Request function codes
    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             absorb;
        logic             finish;
        logic             shift_pad;
        logic             shift_zero;
        logic             shift_len;
        logic             comp_start;
        logic             comp_round;
        logic             fold;
        logic             clear;
        logic [IDX_W-1:0] out_idx;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              ovf;
        logic              round_last;
    } dp_sts_t;

    function automatic word_t init_hash(input logic [IDX_W-1:0] idx);
        word_t val;
        case (idx)
            3'd0:    val = 32'h6A09E667;
            3'd1:    val = 32'hBB67AE85;
            3'd2:    val = 32'h3C6EF372;
            3'd3:    val = 32'hA54FF53A;
            3'd4:    val = 32'h510E527F;
            3'd5:    val = 32'h9B05688C;
            3'd6:    val = 32'h1F83D9AB;
            default: val = 32'h5BE0CD19;
        endcase
        return val;
    endfunction

    function automatic word_t round_k(input logic [ROUND_W-1:0] t);
        word_t val;
        case (t)
            6'd0:  val = 32'h428a2f98;  6'd1:  val = 32'h71374491;
            6'd2:  val = 32'hb5c0fbcf;  6'd3:  val = 32'he9b5dba5;
            6'd4:  val = 32'h3956c25b;  6'd5:  val = 32'h59f111f1;
            6'd6:  val = 32'h923f82a4;  6'd7:  val = 32'hab1c5ed5;
            6'd8:  val = 32'hd807aa98;  6'd9:  val = 32'h12835b01;
            6'd10: val = 32'h243185be;  6'd11: val = 32'h550c7dc3;
            6'd12: val = 32'h72be5d74;  6'd13: val = 32'h80deb1fe;
            6'd14: val = 32'h9bdc06a7;  6'd15: val = 32'hc19bf174;
            6'd16: val = 32'he49b69c1;  6'd17: val = 32'hefbe4786;
            6'd18: val = 32'h0fc19dc6;  6'd19: val = 32'h240ca1cc;
            6'd20: val = 32'h2de92c6f;  6'd21: val = 32'h4a7484aa;
            6'd22: val = 32'h5cb0a9dc;  6'd23: val = 32'h76f988da;
            6'd24: val = 32'h983e5152;  6'd25: val = 32'ha831c66d;
            6'd26: val = 32'hb00327c8;  6'd27: val = 32'hbf597fc7;
            6'd28: val = 32'hc6e00bf3;  6'd29: val = 32'hd5a79147;
            6'd30: val = 32'h06ca6351;  6'd31: val = 32'h14292967;
            6'd32: val = 32'h27b70a85;  6'd33: val = 32'h2e1b2138;
            6'd34: val = 32'h4d2c6dfc;  6'd35: val = 32'h53380d13;
            6'd36: val = 32'h650a7354;  6'd37: val = 32'h766a0abb;
            6'd38: val = 32'h81c2c92e;  6'd39: val = 32'h92722c85;
            6'd40: val = 32'ha2bfe8a1;  6'd41: val = 32'ha81a664b;
            6'd42: val = 32'hc24b8b70;  6'd43: val = 32'hc76c51a3;
            6'd44: val = 32'hd192e819;  6'd45: val = 32'hd6990624;
            6'd46: val = 32'hf40e3585;  6'd47: val = 32'h106aa070;
            6'd48: val = 32'h19a4c116;  6'd49: val = 32'h1e376c08;
            6'd50: val = 32'h2748774c;  6'd51: val = 32'h34b0bcb5;
            6'd52: val = 32'h391c0cb3;  6'd53: val = 32'h4ed8aa4a;
            6'd54: val = 32'h5b9cca4f;  6'd55: val = 32'h682e6ff3;
            6'd56: val = 32'h748f82ee;  6'd57: val = 32'h78a5636f;
            6'd58: val = 32'h84c87814;  6'd59: val = 32'h8cc70208;
            6'd60: val = 32'h90befffa;  6'd61: val = 32'ha4506ceb;
            6'd62: val = 32'hbef9a3f7;  default: val = 32'hc67178f2;
        endcase
        return val;
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

FILE: rtl/sha256bsh_in_if.sv
interface sha256bsh_in_if
    import sha256bsh_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic               func;
    logic [BYTE_W-1:0]  data_byte;
    logic [EXTRA_W-1:0] extra_bits;

    modport source (output valid, output func, output data_byte, output extra_bits,
                    input ready);
    modport sink   (input valid, input func, input data_byte, input extra_bits,
                    output ready);
endinterface

FILE: rtl/sha256bsh_out_if.sv
interface sha256bsh_out_if
    import sha256bsh_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [WORD_W-1:0] digest_word;
    logic [IDX_W-1:0] word_index;
    logic             last;
    logic             status;

    modport source (output valid, output digest_word, output word_index, output last,
                    output status, input ready);
    modport sink   (input valid, input digest_word, input word_index, input last,
                    input status, output ready);
endinterface

FILE: rtl/sha256bsh_datapath.sv
module sha256bsh_datapath
    import sha256bsh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic [EXTRA_W-1:0] extra_bits,
    output dp_sts_t            sts,
    output word_t              digest_word
);

    word_t              hash_reg [HASH_WORDS];
    word_t              v_reg    [HASH_WORDS];
    logic [BLOCK_W-1:0] blk_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               ovf_reg;
    logic [ROUND_W-1:0] round_reg;
    logic [BYTE_W-1:0]  pad_reg;

    logic [LEN_W:0]     sum8;
    logic [LEN_W:0]     sumx;
    logic [FILL_W-1:0]  fill_inc;
    logic               byte_en;
    logic [BYTE_W-1:0]  byte_in;
    logic [5:0]         len_lsb;
    logic [BYTE_W-1:0]  pad_next;
    word_t              w_cur;
    word_t              w_new;
    word_t              t1;
    word_t              t2;

    // Length adders with carry out for overflow detection
    assign sum8     = {1'b0, len_reg} + (LEN_W + 1)'(BYTE_W);
    assign sumx     = {1'b0, len_reg} + {{(LEN_W + 1 - EXTRA_W){1'b0}}, extra_bits};
    assign fill_inc = {1'b0, fill_reg[5:0]} + 7'd1;

    // Pad byte: kept trailing bits, then the mark bit
    assign pad_next = (data_byte & 8'(16'hFF00 >> extra_bits)) | (8'h80 >> extra_bits);

    // Pick the byte that enters the block buffer
    assign len_lsb = {~fill_reg[2:0], 3'b000};
    always_comb
    begin
        byte_in = data_byte;
        if (cmd.shift_pad)
        begin
            byte_in = pad_reg;
        end
        else if (cmd.shift_zero)
        begin
            byte_in = '0;
        end
        else if (cmd.shift_len)
        begin
            byte_in = len_reg[len_lsb +: BYTE_W];
        end
    end

    assign byte_en = (cmd.absorb && !ovf_reg && !sum8[LEN_W])
                   || cmd.shift_pad || cmd.shift_zero || cmd.shift_len;

    // Message schedule taps on the block shift line
    assign w_cur = blk_reg[BLOCK_W-1 -: WORD_W];
    assign w_new = small_sigma1(blk_reg[BLOCK_W-1-14*WORD_W -: WORD_W])
                 + blk_reg[BLOCK_W-1-9*WORD_W -: WORD_W]
                 + small_sigma0(blk_reg[BLOCK_W-1-WORD_W -: WORD_W])
                 + w_cur;

    // One compression round
    assign t1 = v_reg[7] + big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + round_k(round_reg) + w_cur;
    assign t2 = big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // Control state: hash, length, fill, overflow, round
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                hash_reg[i] <= init_hash(IDX_W'(i));
            end
            len_reg   <= '0;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            round_reg <= '0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                hash_reg[i] <= init_hash(IDX_W'(i));
            end
            len_reg  <= '0;
            fill_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.absorb && !ovf_reg)
            begin
                if (sum8[LEN_W])
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    len_reg <= sum8[LEN_W-1:0];
                end
            end
            if (cmd.finish && !ovf_reg)
            begin
                if (sumx[LEN_W])
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    len_reg <= sumx[LEN_W-1:0];
                end
            end
            if (byte_en)
            begin
                fill_reg <= fill_inc;
            end
            if (cmd.fold)
            begin
                fill_reg <= '0;
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
                end
            end
            if (cmd.comp_start)
            begin
                round_reg <= '0;
            end
            else if (cmd.comp_round)
            begin
                round_reg <= round_reg + 6'd1;
            end
        end
    end

    // Payload: block shift line, working variables, pad byte
    always_ff @(posedge clk)
    begin
        if (byte_en)
        begin
            blk_reg <= {blk_reg[BLOCK_W-BYTE_W-1:0], byte_in};
        end
        else if (cmd.comp_round)
        begin
            blk_reg <= {blk_reg[BLOCK_W-WORD_W-1:0], w_new};
        end
        if (cmd.finish)
        begin
            pad_reg <= pad_next;
        end
        if (cmd.comp_start)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                v_reg[i] <= hash_reg[i];
            end
        end
        else if (cmd.comp_round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign sts.fill       = fill_reg;
    assign sts.ovf        = ovf_reg;
    assign sts.round_last = (round_reg == ROUND_W'(ROUNDS - 1));

    // Digest word is forced to zero after a length overflow
    assign digest_word = ovf_reg ? '0 : hash_reg[cmd.out_idx];

endmodule

FILE: rtl/sha256bsh_ctrl.sv
module sha256bsh_ctrl
    import sha256bsh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_func,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [IDX_W-1:0] word_index,
    output logic             last,
    output dp_cmd_t          cmd,
    input  dp_sts_t          sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ABS_CHK,
        S_FIN_CHK,
        S_ZERO,
        S_LEN,
        S_COMP,
        S_FOLD,
        S_OUT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    state_t           ret_reg;
    state_t           ret_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    assign word_index = idx_reg;
    assign last       = (idx_reg == IDX_W'(DIGEST_WORDS - 1));

    // Sequence absorb, padding, compression and digest output
    always_comb
    begin
        cmd         = '0;
        cmd.out_idx = idx_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        state_next  = state_reg;
        ret_next    = ret_reg;
        idx_next    = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_func == FUNC_ABSORB)
                    begin
                        cmd.absorb = 1'b1;
                        state_next = S_ABS_CHK;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_FIN_CHK;
                    end
                end
            end
            S_ABS_CHK:
            begin
                if (sts.fill == FILL_W'(BLOCK_BYTES))
                begin
                    cmd.comp_start = 1'b1;
                    ret_next       = S_IDLE;
                    state_next     = S_COMP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FIN_CHK:
            begin
                idx_next = '0;
                if (sts.ovf)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.shift_pad = 1'b1;
                    state_next    = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (sts.fill == FILL_W'(LEN_START))
                begin
                    state_next = S_LEN;
                end
                else if (sts.fill == FILL_W'(BLOCK_BYTES))
                begin
                    cmd.comp_start = 1'b1;
                    ret_next       = S_ZERO;
                    state_next     = S_COMP;
                end
                else
                begin
                    cmd.shift_zero = 1'b1;
                end
            end
            S_LEN:
            begin
                if (sts.fill == FILL_W'(BLOCK_BYTES))
                begin
                    cmd.comp_start = 1'b1;
                    ret_next       = S_OUT;
                    state_next     = S_COMP;
                end
                else
                begin
                    cmd.shift_len = 1'b1;
                end
            end
            S_COMP:
            begin
                cmd.comp_round = 1'b1;
                if (sts.round_last)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                idx_next   = '0;
                state_next = ret_reg;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (last)
                    begin
                        cmd.clear  = 1'b1;
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, return point and word index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

FILE: rtl/sha256_byte_stream_hasher_unit.sv
// SHA-256 hasher for a byte stream.
// Input channel in_ch: one request per message byte (func absorb), or a
// finish request (func finish) whose data_byte high bits carry 0 to 7
// trailing bits, counted by extra_bits.
// An absorb request passes through S_IDLE and S_ABS_CHK; every 64th byte adds
// a compression (64 rounds on one shared round unit and one fold; the start
// shares the check cycle).
// A finish request pads the block byte by byte through the block shift line
// and runs one or two compressions: one when the padding fits the current
// block, two when it spills into a second one, and none after a length
// overflow. Words then leave one per cycle while the receiver is ready.
// Output channel out_ch: DIGEST_WORDS words, word_index 0 first, last set on
// the final word, status set if the 64-bit bit length overflowed (digest
// words then read zero). A stalled receiver holds the current word; no new
// request is taken until the last word is delivered, after which the block
// returns to the initial hash on its own.
// Reset (rst_n low, asynchronous) loads the initial hash and clears the
// length, fill count and overflow flag; no clearing pass is needed.
module sha256_byte_stream_hasher_unit
    import sha256bsh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sha256bsh_in_if.sink    in_ch,
    sha256bsh_out_if.source out_ch
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequence controller
    sha256bsh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_func    (in_ch.func),
        .in_ready   (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .word_index (out_ch.word_index),
        .last       (out_ch.last),
        .cmd        (cmd),
        .sts        (sts)
    );

    // Buffer, length counter and round unit
    sha256bsh_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (in_ch.data_byte),
        .extra_bits  (in_ch.extra_bits),
        .sts         (sts),
        .digest_word (out_ch.digest_word)
    );

    assign out_ch.status = sts.ovf;

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

// One digest word as it leaves the hasher
typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
    logic        status;
} digest_beat_t;

// Tracks the message state of the hasher and checks its digest words
class digest_scoreboard;
    bit [31:0]    round_const [64];
    bit [31:0]    start_hash [8];
    bit [31:0]    hash_state [8];
    bit [7:0]     block_bytes [64];
    int unsigned  fill;
    bit [63:0]    length_bits;
    bit           length_ovf;
    digest_beat_t expected_words [$];
    int           fail_count;
    int           words_checked;

    function new();
        round_const = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        start_hash = '{
            32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
            32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
        };
        fail_count = 0;
        words_checked = 0;
        restart();
    endfunction

    // Return to the initial hash with an empty message
    function void restart();
        hash_state = start_hash;
        foreach (block_bytes[i])
            block_bytes[i] = 8'h00;
        fill = 0;
        length_bits = 64'd0;
        length_ovf = 1'b0;
    endfunction

    function bit [31:0] rotr(bit [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Fold the block buffer into the hash state
    function void compress_block();
        bit [31:0] w [64];
        bit [31:0] v [8];
        bit [31:0] e, a, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                    block_bytes[4*t+3]};
        for (int t = 16; t < 64; t++)
        begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        v = hash_state;
        for (int t = 0; t < 64; t++)
        begin
            e = v[4];
            a = v[0];
            t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
                 ((e & v[5]) ^ (~e & v[6])) + round_const[t] + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
                 ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = e;
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = a;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
        fill = 0;
    endfunction

    // Grow the bit length; flag and refuse a wrap past 64 bits
    function bit add_length(int unsigned n);
        bit [64:0] sum;
        sum = {1'b0, length_bits} + n;
        if (sum[64])
        begin
            length_ovf = 1'b1;
            return 1'b0;
        end
        length_bits = sum[63:0];
        return 1'b1;
    endfunction

    // Append the pad byte, zeros and the bit length, one or two blocks
    function void pad_and_close(bit [7:0] pad);
        block_bytes[fill % 64] = pad;
        fill = fill % 64 + 1;
        if (fill > 56)
        begin
            while (fill < 64)
            begin
                block_bytes[fill] = 8'h00;
                fill++;
            end
            compress_block();
        end
        while (fill < 56)
        begin
            block_bytes[fill] = 8'h00;
            fill++;
        end
        for (int i = 0; i < 8; i++)
            block_bytes[56 + i] = length_bits[63 - 8*i -: 8];
        compress_block();
    endfunction

    // Note an accepted request and queue the digest words it causes
    function void note_request(logic fn, logic [7:0] data, logic [2:0] extra);
        bit [15:0]    keep;
        bit [7:0]     pad;
        bit           status;
        digest_beat_t beat;
        if (fn == sha256bsh_pkg::FUNC_ABSORB)
        begin
            if (!length_ovf && add_length(8))
            begin
                block_bytes[fill % 64] = data;
                fill = fill % 64 + 1;
                if (fill == 64)
                    compress_block();
            end
            return;
        end
        if (!length_ovf)
        begin
            pad = 8'h80;
            if (extra != 3'd0)
            begin
                keep = 16'hFF00 >> extra;
                pad = (data & keep[7:0]) | (8'h80 >> extra);
                void'(add_length(extra));
            end
            if (!length_ovf)
                pad_and_close(pad);
        end
        status = length_ovf;
        for (int k = 0; k < sha256bsh_pkg::DIGEST_WORDS; k++)
        begin
            beat.word = status ? 32'd0 : hash_state[k % 8];
            beat.index = 3'(k);
            beat.last = (k == sha256bsh_pkg::DIGEST_WORDS - 1);
            beat.status = status;
            expected_words.push_back(beat);
        end
        restart();
    endfunction

    function void note_failure(string what);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $time, what);
    endfunction

    // Compare one delivered digest word with the oldest expected one
    function void check_word(logic [31:0] word, logic [2:0] index, logic last,
                             logic status);
        digest_beat_t want;
        words_checked++;
        if (expected_words.size() == 0)
        begin
            note_failure($sformatf("unexpected word %h idx %0d last %b status %b",
                                   word, index, last, status));
            return;
        end
        want = expected_words.pop_front();
        if (word !== want.word || index !== want.index || last !== want.last ||
            status !== want.status)
            note_failure($sformatf(
                "digest mismatch: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                want.word, want.index, want.last, want.status,
                word, index, last, status));
    endfunction

    function int words_waiting();
        return expected_words.size();
    endfunction
endclass

module tb;
    import sha256bsh_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int TARGET_ITEMS   = 360;
    localparam int LONG_HOLD      = 400;
    localparam int TAIL_CYCLES    = 300;

    logic clk = 1'b0;
    logic rst_n;
    int   requests_sent = 0;
    bit   long_hold_done = 1'b0;

    digest_scoreboard sb = new();

    sha256bsh_in_if  in_ch ();
    sha256bsh_out_if out_ch ();

    sha256_byte_stream_hasher_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #10 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request and hold it until the hasher takes it
    task automatic send_request(input logic fn, input logic [7:0] data,
                                input logic [2:0] extra, input bit steady);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= fn;
        in_ch.data_byte  <= data;
        in_ch.extra_bits <= extra;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_request(fn, data, extra);
        requests_sent++;
    endtask

    // Send a message of random bytes closed by a finish request
    task automatic send_message(input int nbytes, input logic [2:0] extra,
                                input logic [7:0] tail);
        bit steady;
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < nbytes; i++)
            send_request(FUNC_ABSORB, 8'($urandom_range(0, 255)),
                         3'($urandom_range(0, 7)), steady);
        send_request(FUNC_FINISH, tail, extra, steady);
    endtask

    // Drive reset and all stimulus, then wait for the last digest
    initial
    begin
        int r;
        int nbytes;
        logic [2:0] extra;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.func       <= FUNC_ABSORB;
        in_ch.data_byte  <= 8'h00;
        in_ch.extra_bits <= 3'd0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty messages: data byte ignored, seven trailing bits, one trailing bit
        send_message(0, 3'd0, 8'hFF);
        send_message(0, 3'd7, 8'hFF);
        send_message(0, 3'd1, 8'h00);
        // Classic three-byte message
        send_request(FUNC_ABSORB, 8'h61, 3'd0, 1'b1);
        send_request(FUNC_ABSORB, 8'h62, 3'd7, 1'b1);
        send_request(FUNC_ABSORB, 8'h63, 3'd0, 1'b1);
        send_request(FUNC_FINISH, 8'h00, 3'd0, 1'b1);
        // Extreme bytes with partial trailing bits
        send_request(FUNC_ABSORB, 8'h00, 3'd0, 1'b0);
        send_message(0, 3'd3, 8'hA5);
        send_request(FUNC_ABSORB, 8'hFF, 3'd7, 1'b0);
        send_request(FUNC_ABSORB, 8'h00, 3'd0, 1'b0);
        send_message(0, 3'd5, 8'h5A);

        // Random messages, weighted toward block and padding boundaries
        while (requests_sent < TARGET_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                nbytes = $urandom_range(0, 20);
            else if (r == 5)
            begin
                case ($urandom_range(0, 4))
                    0:       nbytes = 55;
                    1:       nbytes = 56;
                    2:       nbytes = 57;
                    3:       nbytes = 63;
                    default: nbytes = 64;
                endcase
            end
            else if (r < 8)
                nbytes = $urandom_range(21, 70);
            else if (r == 8)
                nbytes = $urandom_range(100, 140);
            else
                nbytes = 0;
            // Keep the last message within the item budget
            if (nbytes > TARGET_ITEMS - requests_sent)
                nbytes = TARGET_ITEMS - requests_sent;
            extra = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
            send_message(nbytes, extra, 8'($urandom_range(0, 255)));
        end
        in_ch.valid <= 1'b0;

        while (sb.words_waiting() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Take digest words with random stalls and one long hold-off
    initial
    begin
        int  hold_left;
        bit  steady;
        hold_left = 0;
        steady = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last,
                              out_ch.status);
            if ($urandom_range(0, 63) == 0)
                steady = !steady;
            if (!long_hold_done && out_ch.valid && sb.words_checked >= 8)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!steady && $urandom_range(0, 9) < 3)
                    hold_left = pick_gap();
            end
        end
    end

    // Stop a hung run
    initial
    begin
        #25_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule
